### hdl/first_fit_block_allocator_assert.svh
// Assertion macros for the allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Condition that must hold on every clock edge out of reset.
`define FFBA_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("allocator check failed");

// Same-cycle implication.
`define FFBA_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

`endif

### hdl/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

  localparam int ADDR_W = 20;
  localparam int SIZE_W = 21;
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;

  localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_W;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [ST_W-1:0] ST_NOFIT    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FREED    = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

  // One table entry
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              used;
  } ent_t;

  // Table update broadcast to all cells
  typedef struct packed {
    logic wr_en;
    logic ins_en;
    logic del_en;
    ent_t wr_ent;
    ent_t ins_ent;
  } ctl_t;

endpackage
`default_nettype wire

### hdl/ffba_cell.sv
`default_nettype none
module ffba_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  wire                   clk,
  input  wire ffba_pkg::ctl_t   ctl,
  input  wire [IW-1:0]          wr_idx,
  input  wire [IW-1:0]          sh_idx,
  input  wire ffba_pkg::ent_t   prev_i,
  input  wire ffba_pkg::ent_t   next_i,
  output ffba_pkg::ent_t        q_o
);
  import ffba_pkg::*;

  localparam logic [IW-1:0] MY = IW'(IDX);

  ent_t ent_r, ent_nxt;

  // shift down on delete, up on insert, else local write
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.del_en && (MY >= sh_idx)) begin
      ent_nxt = next_i;
    end else if (ctl.ins_en && (MY > sh_idx)) begin
      ent_nxt = prev_i;
    end else if (ctl.ins_en && (MY == sh_idx)) begin
      ent_nxt = ctl.ins_ent;
    end else if (ctl.wr_en && (MY == wr_idx)) begin
      ent_nxt = ctl.wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q_o = ent_r;

endmodule
`default_nettype wire

### hdl/first_fit_block_allocator.sv
// Run time from input accept to result accept is set by the scans of the block table,
// one cell read per cycle (first fit, address search, merges); a moving resize
// scans the table three times.
// One word at a time: the next word is taken once the result is registered, even
// while that result still waits on out_tready.
// Reset (rst_n low, synchronous): one free block covering 2^20 bytes.
`default_nettype none
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire [20:0]  cfg_wr_data,   // pool_size
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [47:0]  in_tdata,      // req_size[20:0], address[40:21], zero pad
  input  wire [1:0]   in_tuser,      // operation[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,     // result_address[19:0], zero pad
  output logic [3:0]  out_tuser      // status[2:0], moved[3]
);
  import ffba_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ASCAN = 10'b0000000010,
    S_FSCAN = 10'b0000000100,
    S_FR0   = 10'b0000001000,
    S_FR1   = 10'b0000010000,
    S_FR2   = 10'b0000100000,
    S_RZ0   = 10'b0001000000,
    S_RZ1   = 10'b0010000000,
    S_RZ2   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t             st_r, st_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [IW-1:0]      k_r, k_nxt;
  logic [SIZE_W-1:0]  tmp_r, tmp_nxt;
  logic [ADDR_W-1:0]  kst_r, kst_nxt;
  logic               kused_r, kused_nxt;
  logic               sec_r, sec_nxt;
  logic [ADDR_W-1:0]  nadr_r, nadr_nxt;
  logic [ST_W-1:0]    fst_r, fst_nxt;
  logic [ADDR_W-1:0]  fres_r, fres_nxt;
  logic [ST_W-1:0]    fstat_r, fstat_nxt;
  logic               fmv_r, fmv_nxt;
  logic               out_v_r, out_v_nxt;
  logic [ADDR_W-1:0]  ores_r;
  logic [ST_W-1:0]    ostat_r;
  logic               omv_r;

  ctl_t          ctl;
  logic [IW-1:0] wr_idx, sh_idx;
  ent_t          cell_q [MAX_BLOCKS];
  ent_t          rd;

  logic [SIZE_W-1:0] cfg_pool;
  logic              in_fire, out_load;

  assign in_tready = (st_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (st_r == S_DONE) && (!out_v_r || out_tready);
  assign rd        = cell_q[ptr_r[IW-1:0]];

  // pool size clamp to 1 .. 2^20
  always_comb begin
    cfg_pool = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      cfg_pool = SIZE_W'(1);
    end else if (cfg_wr_data > POOL_MAX) begin
      cfg_pool = POOL_MAX;
    end
  end

  // Cell chain
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ent_t prv, nxt;
    if (g == 0) begin : g_first
      assign prv = cell_q[0];
    end else begin : g_mid
      assign prv = cell_q[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_last
      assign nxt = cell_q[g];
    end else begin : g_inner
      assign nxt = cell_q[g+1];
    end
    ffba_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .sh_idx (sh_idx),
      .prev_i (prv),
      .next_i (nxt),
      .q_o    (cell_q[g])
    );
  end

  // Sequencer
  always_comb begin
    logic              a_done, f_done, f_hit, r_done, fin;
    logic [ST_W-1:0]   a_st, fin_st;
    logic [ADDR_W-1:0] a_adr, fin_res;
    logic              fin_mv;
    logic [SIZE_W:0]   sum;

    st_nxt = st_r;     op_nxt = op_r;     size_nxt = size_r;  addr_nxt = addr_r;
    ptr_nxt = ptr_r;   cnt_nxt = cnt_r;   k_nxt = k_r;        tmp_nxt = tmp_r;
    kst_nxt = kst_r;   kused_nxt = kused_r; sec_nxt = sec_r;  nadr_nxt = nadr_r;
    fst_nxt = fst_r;   fres_nxt = fres_r; fstat_nxt = fstat_r; fmv_nxt = fmv_r;
    ctl = '0;
    wr_idx = ptr_r[IW-1:0];
    sh_idx = ptr_r[IW-1:0];
    a_done = 1'b0; f_done = 1'b0; f_hit = 1'b0; r_done = 1'b0; fin = 1'b0;
    a_st = ST_OK; a_adr = '0; fin_st = ST_OK; fin_res = '0; fin_mv = 1'b0;
    sum = {1'b0, tmp_r} + {1'b0, rd.size};

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_tuser;
          size_nxt = in_tdata[20:0];
          addr_nxt = in_tdata[40:21];
          sec_nxt  = 1'b0;
          ptr_nxt  = '0;
          case (in_tuser) inside
            OP_ALLOC:            st_nxt = S_ASCAN;
            OP_FREE, OP_RESIZE:  st_nxt = S_FSCAN;
            default:             fin = 1'b1;
          endcase
        end
      end
      // first-fit scan
      S_ASCAN: begin
        if (size_r == '0) begin
          a_done = 1'b1; a_st = ST_ZERO;
        end else if (ptr_r >= cnt_r) begin
          a_done = 1'b1; a_st = ST_NOFIT;
        end else if (!rd.used && (size_r <= rd.size)) begin
          if (rd.size != size_r) begin
            if (cnt_r == CNT_MAX) begin
              a_done = 1'b1; a_st = ST_FULL;
            end else begin
              ctl.ins_en        = 1'b1;
              sh_idx            = ptr_r[IW-1:0] + IW'(1);
              ctl.ins_ent.start = rd.start + size_r[ADDR_W-1:0];
              ctl.ins_ent.size  = rd.size - size_r;
              ctl.ins_ent.used  = 1'b0;
              ctl.wr_en         = 1'b1;
              ctl.wr_ent        = '{start: rd.start, size: size_r, used: 1'b1};
              cnt_nxt           = cnt_r + CW'(1);
              a_done = 1'b1; a_adr = rd.start;
            end
          end else begin
            ctl.wr_en  = 1'b1;
            ctl.wr_ent = '{start: rd.start, size: rd.size, used: 1'b1};
            a_done = 1'b1; a_adr = rd.start;
          end
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      // address search
      S_FSCAN: begin
        if (ptr_r >= cnt_r) begin
          f_done = 1'b1;
        end else if (rd.start == addr_r) begin
          f_done = 1'b1; f_hit = 1'b1;
          k_nxt  = ptr_r[IW-1:0];
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      // free: mark entry k free
      S_FR0: begin
        fst_nxt    = rd.used ? ST_OK : ST_FREED;
        ctl.wr_en  = 1'b1;
        ctl.wr_ent = '{start: rd.start, size: rd.size, used: 1'b0};
        tmp_nxt    = rd.size;
        kst_nxt    = rd.start;
        if (k_r != '0) begin
          ptr_nxt = {1'b0, k_r} - CW'(1);
          st_nxt  = S_FR1;
        end else begin
          ptr_nxt = {1'b0, k_r} + CW'(1);
          st_nxt  = S_FR2;
        end
      end
      // merge with left neighbor
      S_FR1: begin
        if (!rd.used) begin
          ctl.wr_en  = 1'b1;
          ctl.wr_ent = '{start: rd.start, size: sum[SIZE_W-1:0], used: 1'b0};
          ctl.del_en = 1'b1;
          sh_idx     = k_r;
          cnt_nxt    = cnt_r - CW'(1);
          tmp_nxt    = sum[SIZE_W-1:0];
          kst_nxt    = rd.start;
          k_nxt      = ptr_r[IW-1:0];
          ptr_nxt    = ptr_r + CW'(1);
        end else begin
          ptr_nxt = {1'b0, k_r} + CW'(1);
        end
        st_nxt = S_FR2;
      end
      // merge with right neighbor
      S_FR2: begin
        if ((ptr_r < cnt_r) && !rd.used) begin
          ctl.wr_en  = 1'b1;
          wr_idx     = k_r;
          ctl.wr_ent = '{start: kst_r, size: sum[SIZE_W-1:0], used: 1'b0};
          ctl.del_en = 1'b1;
          cnt_nxt    = cnt_r - CW'(1);
        end
        r_done = 1'b1;
      end
      // resize: compare against current size
      S_RZ0: begin
        kused_nxt = rd.used;
        tmp_nxt   = rd.size;
        if (rd.size == size_r) begin
          fin = 1'b1; fin_res = addr_r;
        end else if (rd.size < size_r) begin
          ptr_nxt = {1'b0, k_r} + CW'(1);
          st_nxt  = S_RZ1;
        end else begin
          st_nxt = S_FR0;
        end
      end
      // grow in place into the following free block
      S_RZ1: begin
        if ((ptr_r < cnt_r) && !rd.used && (sum >= {1'b0, size_r})) begin
          if (sum == {1'b0, size_r}) begin
            ctl.del_en = 1'b1;
            cnt_nxt    = cnt_r - CW'(1);
          end else begin
            ctl.wr_en        = 1'b1;
            ctl.wr_ent.start = addr_r + size_r[ADDR_W-1:0];
            ctl.wr_ent.size  = SIZE_W'(sum - {1'b0, size_r});
            ctl.wr_ent.used  = 1'b0;
          end
          st_nxt = S_RZ2;
        end else begin
          ptr_nxt = '0;
          st_nxt  = S_ASCAN;
        end
      end
      S_RZ2: begin
        ctl.wr_en  = 1'b1;
        wr_idx     = k_r;
        ctl.wr_ent = '{start: addr_r, size: size_r, used: kused_r};
        fin = 1'b1; fin_res = addr_r;
      end
      S_DONE: begin
        if (out_load) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    // end of an allocation
    if (a_done) begin
      nadr_nxt = a_adr;
      if (op_r == OP_RESIZE && !sec_r && a_st == ST_OK) begin
        sec_nxt = 1'b1;
        ptr_nxt = '0;
        st_nxt  = S_FSCAN;
      end else begin
        fin    = 1'b1;
        fin_st = a_st;
        if (a_st == ST_OK) begin
          fin_res = a_adr;
          fin_mv  = (op_r == OP_RESIZE) && (a_adr != addr_r);
        end
      end
    end
    // end of an address search
    if (f_done) begin
      if (!f_hit) begin
        fin = 1'b1; fin_st = ST_NOTFOUND;
      end else if (op_r == OP_RESIZE && !sec_r) begin
        st_nxt = S_RZ0;
      end else begin
        st_nxt = S_FR0;
      end
    end
    // end of a free
    if (r_done) begin
      if (op_r == OP_FREE) begin
        fin = 1'b1; fin_st = fst_r;
      end else if (!sec_r) begin
        sec_nxt = 1'b1;
        ptr_nxt = '0;
        st_nxt  = S_ASCAN;
      end else begin
        fin = 1'b1; fin_res = nadr_r; fin_mv = (nadr_r != addr_r);
      end
    end
    if (fin) begin
      fres_nxt  = fin_res;
      fstat_nxt = fin_st;
      fmv_nxt   = fin_mv;
      st_nxt    = S_DONE;
    end

    // configuration write rebuilds the table
    if (cfg_wr_en) begin
      cnt_nxt = CW'(1);
      ptr_nxt = '0;
    end
    if (!rst_n || cfg_wr_en) begin
      ctl        = '0;
      ctl.wr_en  = 1'b1;
      wr_idx     = '0;
      ctl.wr_ent = '{start: '0, size: (rst_n ? cfg_pool : POOL_MAX), used: 1'b0};
    end
  end

  // Output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cnt_r   <= CW'(1);
      ptr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;    size_r  <= size_nxt;  addr_r  <= addr_nxt;
    k_r     <= k_nxt;     tmp_r   <= tmp_nxt;   kst_r   <= kst_nxt;
    kused_r <= kused_nxt; sec_r   <= sec_nxt;   nadr_r  <= nadr_nxt;
    fst_r   <= fst_nxt;   fres_r  <= fres_nxt;  fstat_r <= fstat_nxt;
    fmv_r   <= fmv_nxt;
    if (out_load) begin
      ores_r  <= fres_r;
      ostat_r <= fstat_r;
      omv_r   <= fmv_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, ores_r};
  assign out_tuser  = {omv_r, ostat_r};

  // Checks
  `include "first_fit_block_allocator_assert.svh"

  `FFBA_ALWAYS(a_cnt_range, (cnt_r != '0) && (cnt_r <= CNT_MAX))
  `FFBA_ALWAYS(a_ptr_in_table, ptr_r <= cnt_r)
  `FFBA_IMPLIES(a_k_valid, st_r == S_FR0 || st_r == S_RZ0 || st_r == S_RZ2, {1'b0, k_r} < cnt_r)

endmodule
`default_nettype wire
